// ----- rtl/ist_pkg.sv -----
package ist_pkg;

    localparam int MAX_BOUNDS = 64;
    localparam int VAL_W      = 32;
    localparam int CNT_W      = $clog2(MAX_BOUNDS + 1);
    localparam int STEP_W     = $clog2(MAX_BOUNDS);

    localparam logic [1:0] OP_ADD    = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_QUERY  = 2'd2;

    typedef struct packed {
        logic [1:0]       operation;
        logic [VAL_W-1:0] range_start;
        logic [VAL_W-1:0] range_end;
    } t_in_item;

    typedef struct packed {
        logic covered;
        logic capacity_error;
    } t_out_item;

    typedef enum logic [2:0] {
        CMD_HOLD,
        CMD_CMP,
        CMD_SCAN,
        CMD_SHIFT,
        CMD_FILL,
        CMD_COMPACT
    } t_cmd;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CMP,
        ST_SCAN,
        ST_DECIDE,
        ST_SHIFT,
        ST_FILL,
        ST_COMPACT,
        ST_DONE
    } t_state;

    // Broadcast from the sequencer to every cell.
    typedef struct packed {
        t_cmd             cmd;
        logic [VAL_W-1:0] range_start;
        logic [VAL_W-1:0] range_end;
        logic [VAL_W-1:0] fill0;
        logic [1:0]       fill_cnt;
    } t_cell_ctrl;

    // Fixed facts about a cell's place in the chain.
    typedef struct packed {
        logic head;
        logic odd;
    } t_cell_pos;

    // Contents of one cell, seen by both neighbours.
    typedef struct packed {
        logic [VAL_W-1:0] value;
        logic             valid;
        logic             zone;
        logic             lt;
        logic             le;
        logic             les;
        logic             gee;
        logic             lpar;
        logic [CNT_W-1:0] mid;
        logic [CNT_W-1:0] cnt;
        logic             hit;
    } t_cell_state;

endpackage

// ----- rtl/ist_cell.sv -----
module ist_cell (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  ist_pkg::t_cell_ctrl  i_ctrl,
    input  ist_pkg::t_cell_pos   i_pos,
    input  ist_pkg::t_cell_state i_left,
    input  logic                i_left2_zone,
    input  ist_pkg::t_cell_state i_right,
    output ist_pkg::t_cell_state o_state
);
    import ist_pkg::*;

    t_cell_state r_cell;
    t_cell_state n_cell;
    logic        w_first;
    logic        w_second;

    assign w_first  = r_cell.zone & ~i_left.zone;
    assign w_second = r_cell.zone & i_left.zone & ~i_left2_zone;

    always_comb begin
        n_cell = r_cell;
        case (i_ctrl.cmd)
            CMD_CMP: begin
                n_cell.lt   = r_cell.valid & (r_cell.value <  i_ctrl.range_start);
                n_cell.le   = r_cell.valid & (r_cell.value <= i_ctrl.range_end);
                n_cell.les  = r_cell.valid & (r_cell.value <= i_ctrl.range_start);
                n_cell.gee  = r_cell.valid & (r_cell.value >= i_ctrl.range_end);
                n_cell.zone = r_cell.valid & ~(r_cell.value < i_ctrl.range_start)
                              & (r_cell.value <= i_ctrl.range_end);
            end
            CMD_SCAN: begin
                // advance the prefix wave by one cell
                n_cell.lpar = i_left.lpar ^ r_cell.lt;
                n_cell.mid  = i_left.mid + CNT_W'(r_cell.le & ~r_cell.lt);
                n_cell.cnt  = i_left.cnt + CNT_W'(r_cell.valid);
                n_cell.hit  = i_left.hit | (r_cell.les & ~i_pos.odd & i_right.valid
                              & ~i_right.les & i_right.gee);
            end
            CMD_SHIFT: begin
                if (!r_cell.lt) begin
                    if (!i_pos.head && !i_left.lt) begin
                        n_cell.value = i_left.value;
                        n_cell.valid = i_left.valid;
                        n_cell.zone  = i_left.zone;
                    end else begin
                        n_cell.zone  = 1'b1;
                        n_cell.valid = 1'b1;
                    end
                end
            end
            CMD_FILL: begin
                if (r_cell.zone) begin
                    n_cell.zone = 1'b0;
                    if (w_first && i_ctrl.fill_cnt != 2'd0) begin
                        n_cell.value = i_ctrl.fill0;
                        n_cell.valid = 1'b1;
                    end else if (w_second && i_ctrl.fill_cnt == 2'd2) begin
                        n_cell.value = i_ctrl.range_end;
                        n_cell.valid = 1'b1;
                    end else begin
                        n_cell.valid = 1'b0;
                    end
                end
            end
            CMD_COMPACT: begin
                // a gap swaps with a filled neighbour on its right
                if (!r_cell.valid && i_right.valid) begin
                    n_cell.value = i_right.value;
                    n_cell.valid = 1'b1;
                end else if (r_cell.valid && !i_pos.head && !i_left.valid) begin
                    n_cell.valid = 1'b0;
                end
            end
            default: begin
                n_cell = r_cell;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell.valid <= 1'b0;
            r_cell.zone  <= 1'b0;
        end else begin
            r_cell <= n_cell;
        end
    end

    assign o_state = r_cell;

endmodule

// ----- rtl/interval_set_tracker_unit.sv -----
// Interval set tracker. The covered set is a sorted list of up to MAX_BOUNDS
// boundaries held one per cell in a chain; even positions open an interval,
// odd positions close one. Each item (add, remove or query of [start,end))
// gives exactly one result item. One item is worked on at a time, in these
// steps: a compare, the count and parity wave crossing the chain, a decision,
// then for an add or remove the shifts, if any, that open slots, a fill, the
// closing of gaps, and last the load of the output register. After the result
// is loaded the unit returns to idle and takes the next item. The wave and the
// gap closing move one cell per cycle, so the chain length sets how long they
// take. A dropped add or remove, like a query, goes from the decision straight
// to the load of the output register.
// The output register lets the next item be accepted while a result waits.
// Empty or reversed ranges and the unused operation code change nothing and
// report zeros. After reset the set is empty.
module interval_set_tracker_unit (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  ist_pkg::t_in_item  i_in_item,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output ist_pkg::t_out_item o_out_item
);
    import ist_pkg::*;

    t_state r_state;
    t_state n_state;

    t_in_item         r_item;
    logic [STEP_W-1:0] r_step;
    logic [STEP_W-1:0] n_step;
    logic [1:0]       r_shl;
    logic [1:0]       n_shl;
    logic [VAL_W-1:0] r_fill0;
    logic [1:0]       r_fill_cnt;
    logic             r_cov;
    logic             r_err;
    logic             r_out_valid;
    t_out_item        r_out_item;

    logic             w_accept;
    logic             w_load;
    t_cmd             w_cmd;
    t_cell_ctrl       w_ctrl;
    t_cell_state      w_last;
    logic             w_keep;
    logic             w_mfirst;
    logic             w_msec;
    logic [1:0]       w_m;
    logic             w_overflow;
    logic [1:0]       w_shifts;
    logic             w_range_ok;
    logic             w_edit;
    logic             w_go;

    t_cell_state w_cell  [MAX_BOUNDS];
    t_cell_state w_left  [MAX_BOUNDS];
    t_cell_state w_right [MAX_BOUNDS];
    logic        w_left2z[MAX_BOUNDS];

    assign w_accept = i_in_valid & o_in_ready;

    // capture the item
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_item <= i_in_item;
        end
    end

    // decision after the wave has crossed the chain
    assign w_last     = w_cell[MAX_BOUNDS-1];
    assign w_keep     = r_item.operation[0];
    assign w_mfirst   = (w_last.lpar == w_keep);
    assign w_msec     = ((w_last.lpar ^ w_last.mid[0]) == w_keep);
    assign w_m        = {1'b0, w_mfirst} + {1'b0, w_msec};
    assign w_overflow = ({1'b0, w_last.cnt} + (CNT_W+1)'(w_m))
                        > ((CNT_W+1)'(MAX_BOUNDS) + {1'b0, w_last.mid});
    assign w_shifts   = (CNT_W'(w_m) > w_last.mid) ? (w_m - w_last.mid[1:0]) : 2'd0;
    assign w_range_ok = r_item.range_start < r_item.range_end;
    assign w_edit     = (r_item.operation == OP_ADD) || (r_item.operation == OP_REMOVE);
    assign w_go       = w_edit & w_range_ok & ~w_overflow;

    always_ff @(posedge i_clk) begin
        if (r_state == ST_DECIDE) begin
            r_fill0    <= w_mfirst ? r_item.range_start : r_item.range_end;
            r_fill_cnt <= w_m;
            r_err      <= w_edit & w_range_ok & w_overflow;
            r_cov      <= (r_item.operation == OP_QUERY) & w_range_ok & w_last.hit;
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_step  <= '0;
            r_shl   <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            r_shl   <= n_shl;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_step     = r_step;
        n_shl      = r_shl;
        o_in_ready = 1'b0;
        w_load     = 1'b0;
        w_cmd      = CMD_HOLD;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_state = ST_CMP;
                end
            end
            ST_CMP: begin
                w_cmd   = CMD_CMP;
                n_step  = '0;
                n_state = ST_SCAN;
            end
            ST_SCAN: begin
                w_cmd  = CMD_SCAN;
                n_step = r_step + 1'b1;
                if (r_step == STEP_W'(MAX_BOUNDS - 1)) begin
                    n_state = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                n_shl = w_shifts;
                if (!w_go) begin
                    n_state = ST_DONE;
                end else if (w_shifts != 2'd0) begin
                    n_state = ST_SHIFT;
                end else begin
                    n_state = ST_FILL;
                end
            end
            ST_SHIFT: begin
                w_cmd = CMD_SHIFT;
                n_shl = r_shl - 1'b1;
                if (r_shl == 2'd1) begin
                    n_state = ST_FILL;
                end
            end
            ST_FILL: begin
                w_cmd   = CMD_FILL;
                n_step  = '0;
                n_state = ST_COMPACT;
            end
            ST_COMPACT: begin
                w_cmd  = CMD_COMPACT;
                n_step = r_step + 1'b1;
                if (r_step == STEP_W'(MAX_BOUNDS - 1)) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                // hold until the output register is free
                if (!r_out_valid || i_out_ready) begin
                    w_load  = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign w_ctrl.cmd         = w_cmd;
    assign w_ctrl.range_start = r_item.range_start;
    assign w_ctrl.range_end   = r_item.range_end;
    assign w_ctrl.fill0       = r_fill0;
    assign w_ctrl.fill_cnt    = r_fill_cnt;

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_item.covered        <= r_cov;
            r_out_item.capacity_error <= r_err;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    // chain of boundary cells; the ends see empty neighbours
    for (genvar g = 0; g < MAX_BOUNDS; g++) begin : g_cell
        if (g == 0) begin : g_head
            assign w_left[g] = '0;
        end else begin : g_body
            assign w_left[g] = w_cell[g-1];
        end
        if (g < 2) begin : g_l2_none
            assign w_left2z[g] = 1'b0;
        end else begin : g_l2
            assign w_left2z[g] = w_cell[g-2].zone;
        end
        if (g == MAX_BOUNDS - 1) begin : g_tail
            assign w_right[g] = '0;
        end else begin : g_next
            assign w_right[g] = w_cell[g+1];
        end

        ist_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctrl       (w_ctrl),
            .i_pos        ('{head: (g == 0), odd: (g % 2 == 1)}),
            .i_left       (w_left[g]),
            .i_left2_zone (w_left2z[g]),
            .i_right      (w_right[g]),
            .o_state      (w_cell[g])
        );
    end

endmodule

// ----- rtl/ist_checker.sv -----
module ist_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              o_in_ready,
    input logic              o_out_valid,
    input logic              i_out_ready,
    input ist_pkg::t_out_item o_out_item
);
    import ist_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_item))
        else $error("result item dropped or changed while stalled");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready ##1 !o_in_ready)
        else $error("new item taken while one is still in work");

    a_one_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_out_item.covered && o_out_item.capacity_error))
        else $error("query answer and capacity error in one result");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result item present after reset");

endmodule

bind interval_set_tracker_unit ist_checker u_ist_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_item  (o_out_item)
);
